/* design/tspa_pkg.sv */
`timescale 1ns / 1ps

package tspa_pkg;

    // Sequencer phases, also the code carried on the result channel
    typedef enum logic [2:0] {
        PH_POLL      = 3'd0,
        PH_CONVERT   = 3'd1,
        PH_WAIT_CONV = 3'd2,
        PH_READ      = 3'd3,
        PH_WAIT_NEXT = 3'd4
    } phase_t;

    // Which bus response an item used
    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_PRESENCE = 2'd1,
        ACT_CONVERT  = 2'd2,
        ACT_READING  = 2'd3
    } action_t;

    // Register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_SETPOINT_A   = 3'd0;
    localparam logic [2:0] REG_SETPOINT_B   = 3'd1;
    localparam logic [2:0] REG_HYSTERESIS   = 3'd2;
    localparam logic [2:0] REG_WAIT_MS      = 3'd3;
    localparam logic [2:0] REG_MAX_FAILURES = 3'd4;

    localparam int unsigned ADDR_W = 5;

    localparam logic [15:0] TEMP_UNKNOWN     = 16'hFFFF;
    localparam logic [15:0] BAD_READ_A       = 16'hFF81; // -127
    localparam logic [15:0] BAD_READ_B       = 16'd850;
    localparam logic [7:0]  FAIL_COUNT_MAX   = 8'hFF;
    localparam logic [31:0] WAIT_MS_RESET    = 32'd1000;
    localparam logic [7:0]  MAX_FAILS_RESET  = 8'd3;

    typedef struct packed {
        logic [15:0] setpoint_a;
        logic [15:0] setpoint_b;
        logic [15:0] hysteresis;
        logic [31:0] wait_ms;
        logic [7:0]  fail_limit;
    } cfg_t;

    // Input item, last field in the lowest bits
    typedef struct packed {
        logic signed [15:0] raw_reading;
        logic               request_ok;
        logic               sensors_present;
        logic [31:0]        now_ms;
    } item_t;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic        sensor_lost;
        logic        lost_event;
        logic        fell_below_b;
        logic        rose_above_b;
        logic        fell_below_a;
        logic        rose_above_a;
        action_t     bus_action;
        phase_t      phase;
        logic [15:0] temperature;
    } result_t;

    localparam int unsigned IN_BITS  = $bits(item_t);
    localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_BITS = $bits(result_t);
    localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Outcome of one setpoint check
    typedef struct packed {
        logic flag;
        logic rise;
        logic fall;
    } alarm_t;

endpackage

/* design/tspa_regs.sv */
`timescale 1ns / 1ps

module tspa_regs
    import tspa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setpoint_a <= '0;
            cfg_reg.setpoint_b <= '0;
            cfg_reg.hysteresis <= '0;
            cfg_reg.wait_ms    <= WAIT_MS_RESET;
            cfg_reg.fail_limit <= MAX_FAILS_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SETPOINT_A:   cfg_reg.setpoint_a <= pwdata[15:0];
                REG_SETPOINT_B:   cfg_reg.setpoint_b <= pwdata[15:0];
                REG_HYSTERESIS:   cfg_reg.hysteresis <= pwdata[15:0];
                REG_WAIT_MS:      cfg_reg.wait_ms    <= pwdata;
                REG_MAX_FAILURES: cfg_reg.fail_limit <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SETPOINT_A:   prdata = {16'd0, cfg_reg.setpoint_a};
            REG_SETPOINT_B:   prdata = {16'd0, cfg_reg.setpoint_b};
            REG_HYSTERESIS:   prdata = {16'd0, cfg_reg.hysteresis};
            REG_WAIT_MS:      prdata = cfg_reg.wait_ms;
            REG_MAX_FAILURES: prdata = {24'd0, cfg_reg.fail_limit};
            default:          prdata = '0;
        endcase
    end

endmodule

/* design/tspa_alarm.sv */
`timescale 1ns / 1ps

module tspa_alarm
    import tspa_pkg::*;
(
    input  logic [15:0] temperature,
    input  logic [15:0] setpoint,
    input  logic [15:0] hysteresis,
    input  logic        flag,
    output alarm_t      result
);

    logic signed [17:0] low_mark;
    logic signed [17:0] temp_s;

    // setpoint - hysteresis may go negative; then nothing falls below it
    assign low_mark = $signed({2'b00, setpoint}) - $signed({2'b00, hysteresis});
    assign temp_s   = $signed({2'b00, temperature});

    always_comb begin
        result.flag = flag;
        result.rise = 1'b0;
        result.fall = 1'b0;
        if (!flag && (temperature > setpoint)) begin
            result.flag = 1'b1;
            result.rise = 1'b1;
        end else if (flag && (temp_s < low_mark)) begin
            result.flag = 1'b0;
            result.fall = 1'b1;
        end
    end

endmodule

/* design/temp_sensor_poll_alarm.sv */
`timescale 1ns / 1ps
// Polling thermostat alarm. Each item on the s_ channel is one tick of the
// sensor sequencer (poll, convert, wait conversion, read, wait next) with
// the millisecond time and the bus responses for that tick. Every item
// gives exactly one result on the m_ channel: held temperature, phase
// after the tick, which response was used, the four setpoint pulses and
// the lost event and level.
// An item taken at one clock edge is in the input register; its result is
// loaded into the output register as soon as the output slot is free.
// Throughput is one item per cycle while m_tready is high: all work for a
// tick (a constant scaling by 25/4, a 32-bit elapsed time compare and two
// setpoint checks) is one pass of logic.
// Stalls: while m_tready is low with a result held, one more item can sit
// in the input register; s_tready drops only when both are full.
// Reset (aresetn low at a clock edge) empties both registers, returns the
// sequencer to poll with temperature 0xFFFF, and loads the register
// defaults (wait 1000 ms, three failures, setpoints and hysteresis zero).
// Configuration goes through the APB port while no item is in flight.
module temp_sensor_poll_alarm
    import tspa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // APB configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // tick input
    input  logic              s_tvalid,
    output logic              s_tready,
    // [31:0] now_ms, [32] sensors_present, [33] request_ok,
    // [49:34] raw_reading, [55:50] zero
    input  logic [IN_W-1:0]   s_tdata,
    // result output
    output logic              m_tvalid,
    input  logic              m_tready,
    // [15:0] temperature, [18:16] phase, [20:19] bus_action,
    // [21] rose_above_a, [22] fell_below_a, [23] rose_above_b,
    // [24] fell_below_b, [25] lost_event, [26] sensor_lost, [31:27] zero
    output logic [OUT_W-1:0]  m_tdata
);

    cfg_t cfg;

    tspa_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------- input register ----------------
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_item_reg;
    logic    advance;

    // the tick in the input register moves on when the output slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= item_t'(s_tdata[IN_BITS-1:0]);
        end
    end

    // ---------------- sequencer state ----------------
    phase_t      phase_reg, phase_next;
    logic [31:0] mark_reg, mark_next;
    logic [15:0] temp_reg, temp_next;
    logic [7:0]  fail_reg, fail_next;
    logic        above_a_reg, above_a_next;
    logic        above_b_reg, above_b_next;
    logic        lost_reg, lost_next;

    // ---------------- tick datapath ----------------
    logic               waited;
    logic               read_ok;
    logic signed [20:0] product;
    logic signed [20:0] biased;
    logic [15:0]        centi;
    logic [7:0]         fail_inc;
    logic               declare_lost;
    logic               fail_now;
    action_t            action;
    logic               ev_lost;
    alarm_t             alarm_a, alarm_b;
    result_t            result;

    assign waited = (in_item_reg.now_ms - mark_reg) >= cfg.wait_ms;

    assign read_ok = (in_item_reg.raw_reading != BAD_READ_A)
                  && (in_item_reg.raw_reading != BAD_READ_B);

    // raw * 25 / 4, truncated toward zero: add 3 before the shift when negative
    assign product = $signed({{5{in_item_reg.raw_reading[15]}}, in_item_reg.raw_reading})
                   * 21'sd25;
    assign biased  = product[20] ? (product + 21'sd3) : product;
    assign centi   = biased[17:2];

    assign fail_inc     = (fail_reg == FAIL_COUNT_MAX) ? FAIL_COUNT_MAX : fail_reg + 8'd1;
    assign declare_lost = (fail_inc >= cfg.fail_limit) && !lost_reg;

    tspa_alarm u_alarm_a (
        .temperature (centi),
        .setpoint    (cfg.setpoint_a),
        .hysteresis  (cfg.hysteresis),
        .flag        (above_a_reg),
        .result      (alarm_a)
    );

    tspa_alarm u_alarm_b (
        .temperature (centi),
        .setpoint    (cfg.setpoint_b),
        .hysteresis  (cfg.hysteresis),
        .flag        (above_b_reg),
        .result      (alarm_b)
    );

    // next phase
    always_comb begin
        unique case (phase_reg)
            PH_POLL:      phase_next = in_item_reg.sensors_present ? PH_CONVERT : PH_WAIT_NEXT;
            PH_CONVERT:   phase_next = in_item_reg.request_ok ? PH_WAIT_CONV : PH_WAIT_NEXT;
            PH_WAIT_CONV: phase_next = waited ? PH_READ : PH_WAIT_CONV;
            PH_READ:      phase_next = PH_WAIT_NEXT;
            PH_WAIT_NEXT: phase_next = waited ? PH_POLL : PH_WAIT_NEXT;
            default:      phase_next = PH_POLL;
        endcase
    end

    // per-phase actions
    always_comb begin
        action       = ACT_NONE;
        fail_now     = 1'b0;
        mark_next    = mark_reg;
        temp_next    = temp_reg;
        fail_next    = fail_reg;
        above_a_next = above_a_reg;
        above_b_next = above_b_reg;
        lost_next    = lost_reg;
        ev_lost      = 1'b0;
        result.rose_above_a = 1'b0;
        result.fell_below_a = 1'b0;
        result.rose_above_b = 1'b0;
        result.fell_below_b = 1'b0;

        unique case (phase_reg)
            PH_POLL: begin
                action = ACT_PRESENCE;
                if (!in_item_reg.sensors_present) begin
                    fail_now  = 1'b1;
                    mark_next = in_item_reg.now_ms;
                end
            end
            PH_CONVERT: begin
                action    = ACT_CONVERT;
                fail_now  = !in_item_reg.request_ok;
                mark_next = in_item_reg.now_ms;
            end
            PH_READ: begin
                action    = ACT_READING;
                mark_next = in_item_reg.now_ms;
                if (read_ok) begin
                    temp_next    = centi;
                    fail_next    = '0;
                    lost_next    = 1'b0;
                    above_a_next = alarm_a.flag;
                    above_b_next = alarm_b.flag;
                    result.rose_above_a = alarm_a.rise;
                    result.fell_below_a = alarm_a.fall;
                    result.rose_above_b = alarm_b.rise;
                    result.fell_below_b = alarm_b.fall;
                end else begin
                    fail_now = 1'b1;
                end
            end
            default: ;
        endcase

        if (fail_now) begin
            fail_next = fail_inc;
            if (declare_lost) begin
                lost_next = 1'b1;
                temp_next = TEMP_UNKNOWN;
                ev_lost   = 1'b1;
            end
        end

        result.temperature = temp_next;
        result.phase       = phase_next;
        result.bus_action  = action;
        result.lost_event  = ev_lost;
        result.sensor_lost = lost_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_POLL;
            mark_reg    <= '0;
            temp_reg    <= TEMP_UNKNOWN;
            fail_reg    <= '0;
            above_a_reg <= 1'b0;
            above_b_reg <= 1'b0;
            lost_reg    <= 1'b0;
        end else if (advance) begin
            phase_reg   <= phase_next;
            mark_reg    <= mark_next;
            temp_reg    <= temp_next;
            fail_reg    <= fail_next;
            above_a_reg <= above_a_next;
            above_b_reg <= above_b_next;
            lost_reg    <= lost_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, out_item_reg};

endmodule
